/* sv/ipac_pkg.sv */
// Shared types and constants for the icon pixel to ARGB converter.
`default_nettype none

package ipac_pkg;

    localparam logic OP_PALETTE = 1'b0;
    localparam logic OP_PIXEL   = 1'b1;

    localparam logic [5:0] DEPTH_1BPP  = 6'd1;
    localparam logic [5:0] DEPTH_4BPP  = 6'd4;
    localparam logic [5:0] DEPTH_8BPP  = 6'd8;
    localparam logic [5:0] DEPTH_24BPP = 6'd24;
    localparam logic [5:0] DEPTH_32BPP = 6'd32;
    localparam logic [5:0] DEPTH_RESET = 6'd32;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
    localparam logic [3:0] NIBBLE_MASK  = 4'hf;
    localparam logic [2:0] COL_MAX      = 3'd7;

    localparam logic REG_PIXEL_DEPTH = 1'b0;

    typedef enum logic [1:0] {
        KIND_INDEXED,
        KIND_RGB,
        KIND_ARGB,
        KIND_BAD
    } t_kind;

    // Pixel decoded in the lookup cycle, waiting for palette read data.
    typedef struct packed {
        t_kind       kind;
        logic        idx_ok;
        logic        masked;
        logic [23:0] direct_color;
        logic [7:0]  alpha;
    } t_s1;

    // Palette port requests: one write and one read per cycle.
    typedef struct packed {
        logic        we;
        logic [7:0]  waddr;
        logic [23:0] wdata;
        logic        re;
        logic [7:0]  raddr;
    } t_ram_req;

endpackage

`default_nettype wire

/* sv/ipac_in_if.sv */
// Input channel: palette writes and pixel words.
`default_nettype none

interface ipac_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [7:0]  palette_slot;
    logic [23:0] palette_color;
    logic [31:0] pixel_data;
    logic [7:0]  mask_byte;
    logic [2:0]  column_low;

    modport source (
        output valid, opcode, palette_slot, palette_color, pixel_data, mask_byte,
               column_low,
        input  ready
    );
    modport sink (
        input  valid, opcode, palette_slot, palette_color, pixel_data, mask_byte,
               column_low,
        output ready
    );
endinterface

`default_nettype wire

/* sv/ipac_out_if.sv */
// Output channel: converted ARGB words.
`default_nettype none

interface ipac_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] argb;
    logic        bad_depth;

    modport source (
        output valid, argb, bad_depth,
        input  ready
    );
    modport sink (
        input  valid, argb, bad_depth,
        output ready
    );
endinterface

`default_nettype wire

/* sv/ipac_ram.sv */
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module ipac_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* sv/ipac_front.sv */
// Input stage: decodes the pixel word, issues palette reads and writes.
`default_nettype none

module ipac_front #(
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    ipac_in_if.sink             i_pix,
    input  wire logic [5:0]     i_depth,
    input  wire logic           i_s1_take,
    output logic                o_s1_valid,
    output ipac_pkg::t_s1       o_s1,
    output ipac_pkg::t_ram_req  o_ram
);

    logic               r_s1_valid;
    logic               n_s1_valid;
    ipac_pkg::t_s1      r_s1;
    ipac_pkg::t_s1      n_s1;
    logic               accept;
    logic               pix_acc;
    logic [7:0]         byte0;
    logic [7:0]         index;
    logic               mask_bit;
    logic [2:0]         bit_sel;

    assign i_pix.ready = !r_s1_valid || i_s1_take;
    assign accept      = i_pix.valid && i_pix.ready;
    assign pix_acc     = accept && (i_pix.opcode == ipac_pkg::OP_PIXEL);

    assign byte0    = i_pix.pixel_data[7:0];
    assign bit_sel  = ipac_pkg::COL_MAX - i_pix.column_low;
    assign mask_bit = i_pix.mask_byte[bit_sel];

    always_comb begin
        index = byte0;
        n_s1.kind         = ipac_pkg::KIND_BAD;
        n_s1.masked       = mask_bit;
        n_s1.direct_color = i_pix.pixel_data[23:0];
        n_s1.alpha        = ipac_pkg::ALPHA_OPAQUE;
        case (i_depth)
            ipac_pkg::DEPTH_1BPP: begin
                n_s1.kind = ipac_pkg::KIND_INDEXED;
                index     = {7'd0, byte0[bit_sel]};
            end
            ipac_pkg::DEPTH_4BPP: begin
                n_s1.kind = ipac_pkg::KIND_INDEXED;
                // even column takes the high nibble
                index     = i_pix.column_low[0] ? {4'd0, byte0[3:0] & ipac_pkg::NIBBLE_MASK}
                                                : {4'd0, byte0[7:4]};
            end
            ipac_pkg::DEPTH_8BPP: begin
                n_s1.kind = ipac_pkg::KIND_INDEXED;
            end
            ipac_pkg::DEPTH_24BPP: begin
                n_s1.kind = ipac_pkg::KIND_RGB;
            end
            ipac_pkg::DEPTH_32BPP: begin
                n_s1.kind   = ipac_pkg::KIND_ARGB;
                n_s1.alpha  = i_pix.pixel_data[31:24];
                n_s1.masked = 1'b0;
            end
            default: begin
                n_s1.kind = ipac_pkg::KIND_BAD;
            end
        endcase
        n_s1.idx_ok = {1'b0, index} < 9'(PALETTE_DEPTH);
    end

    // A write lands at the edge it is accepted, so a read of the same slot
    // in the following cycle already sees it.
    always_comb begin
        o_ram.we    = accept && (i_pix.opcode == ipac_pkg::OP_PALETTE)
                      && ({1'b0, i_pix.palette_slot} < 9'(PALETTE_DEPTH));
        o_ram.waddr = i_pix.palette_slot;
        o_ram.wdata = i_pix.palette_color;
        o_ram.re    = pix_acc && (n_s1.kind == ipac_pkg::KIND_INDEXED);
        o_ram.raddr = index;
    end

    assign n_s1_valid = pix_acc || (r_s1_valid && !i_s1_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
        if (pix_acc) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

endmodule

`default_nettype wire

/* sv/ipac_back.sv */
// Output stage: merges palette data, applies the mask, holds the result.
`default_nettype none

module ipac_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s1_valid,
    input  wire ipac_pkg::t_s1 i_s1,
    input  wire logic [23:0]   i_rdata,
    output logic               o_s1_take,
    ipac_out_if.source         o_res
);

    logic        r_valid;
    logic [31:0] r_argb;
    logic        r_bad;
    logic [31:0] n_argb;
    logic        n_bad;
    logic [23:0] color;
    logic [7:0]  alpha;

    assign o_s1_take = i_s1_valid && (!r_valid || o_res.ready);

    always_comb begin
        color = i_s1.direct_color;
        alpha = i_s1.alpha;
        n_bad = 1'b0;
        case (i_s1.kind)
            ipac_pkg::KIND_INDEXED: color = i_s1.idx_ok ? i_rdata : 24'd0;
            ipac_pkg::KIND_RGB:     color = i_s1.direct_color;
            ipac_pkg::KIND_ARGB:    color = i_s1.direct_color;
            default:                n_bad = 1'b1;
        endcase
        if (i_s1.masked) begin
            alpha = (color != 24'd0) ? ipac_pkg::ALPHA_OPAQUE : ipac_pkg::ALPHA_CLEAR;
        end
        n_argb = n_bad ? 32'd0 : {alpha, color};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s1_take) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
        if (o_s1_take) begin
            r_argb <= n_argb;
            r_bad  <= n_bad;
        end
    end

    assign o_res.valid     = r_valid;
    assign o_res.argb      = r_argb;
    assign o_res.bad_depth = r_bad;

endmodule

`default_nettype wire

/* sv/icon_pixel_to_argb_converter_unit.sv */
// Icon pixel to ARGB converter: top level with APB register and palette RAM.
//
// Usage: words arrive on i_pix. A word with opcode palette write stores a
// 24-bit color in the palette and gives no result. A pixel word yields one
// word on o_argb: the indexed depths (1, 4, 8 bits) look the index up in the
// palette, 24 and 32 bits pass the color straight through, and the AND mask
// sets alpha where it applies. An unsupported depth gives argb zero with
// bad_depth set.
// Order: the palette RAM read runs at the accepting edge beside the lookup
// register, and the output register loads when the lookup entry is taken,
// which a stall on o_argb can hold back.
// Throughput: one word per cycle while o_argb does not stall, set by the
// single read port of the palette RAM and a write port beside it.
// pixel_depth is written over APB at address 0 (reset value 32); write it
// only while no word is in flight.
// Reset clears the pipeline valids and sets the depth register back to 32;
// palette contents are undefined until written and get no clearing pass.
// When the receiver stalls, the output register holds and one more pixel
// waits in the lookup stage; i_pix.ready drops only when both are full.
`default_nettype none

module icon_pixel_to_argb_converter_unit #(
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    ipac_in_if.sink          i_pix,
    ipac_out_if.source       o_argb,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int AW = $clog2(PALETTE_DEPTH);

    logic               depth_wr;
    logic [5:0]         r_pixel_depth;
    logic               s1_valid;
    logic               s1_take;
    ipac_pkg::t_s1      s1;
    ipac_pkg::t_ram_req ram_req;
    logic [23:0]        ram_rdata;

    assign pready = 1'b1;
    assign prdata = (paddr == ipac_pkg::REG_PIXEL_DEPTH) ? {26'd0, r_pixel_depth} : 32'd0;
    assign depth_wr = psel && penable && pwrite && (paddr == ipac_pkg::REG_PIXEL_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_depth <= ipac_pkg::DEPTH_RESET;
        end else if (depth_wr) begin
            r_pixel_depth <= pwdata[5:0];
        end
    end

    ipac_front #(
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (i_pix),
        .i_depth    (r_pixel_depth),
        .i_s1_take  (s1_take),
        .o_s1_valid (s1_valid),
        .o_s1       (s1),
        .o_ram      (ram_req)
    );

    ipac_ram #(
        .WIDTH(24),
        .DEPTH(PALETTE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (AW'(ram_req.waddr)),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (AW'(ram_req.raddr)),
        .o_rdata (ram_rdata)
    );

    ipac_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (s1_valid),
        .i_s1       (s1),
        .i_rdata    (ram_rdata),
        .o_s1_take  (s1_take),
        .o_res      (o_argb)
    );

    // a pixel word accepted must be in the lookup stage next cycle
    a_pixel_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix.valid && i_pix.ready && (i_pix.opcode == ipac_pkg::OP_PIXEL) |=> s1_valid)
        else $error("pixel word lost at lookup stage");

    // a palette write never creates a result
    a_palette_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_valid && !(i_pix.valid && i_pix.ready && (i_pix.opcode == ipac_pkg::OP_PIXEL))
        |=> !s1_valid)
        else $error("lookup stage filled without a pixel word");

    // a stalled lookup stage keeps its pixel
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_valid && !s1_take |=> s1_valid && $stable(s1))
        else $error("lookup stage dropped a pixel");

    // unsupported depth always yields a zero word
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_argb.valid && o_argb.bad_depth |-> (o_argb.argb == 32'd0))
        else $error("bad depth with nonzero argb");

endmodule

`default_nettype wire
